### sv/bmix_pkg.sv
// bmix_pkg: shared types and constants for the batch mixer sequencer
// payload structs, step codes, register indexes and reset durations; no dependencies
`default_nettype none

package bmix_pkg;

    localparam int unsigned DUR_W  = 16;
    localparam int unsigned STEP_W = 3;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned LVL_W  = 6;

    typedef logic [DUR_W-1:0]  t_dur;
    typedef logic [STEP_W-1:0] t_step;
    typedef logic [IDX_W-1:0]  t_cfg_idx;

    // step codes as shown on step_number
    localparam t_step STEP_STANDBY = 3'd0;
    localparam t_step STEP_PUMP_A  = 3'd1;
    localparam t_step STEP_PUMP_B  = 3'd2;
    localparam t_step STEP_WAIT1   = 3'd3;
    localparam t_step STEP_VALVE_C = 3'd4;
    localparam t_step STEP_MIX     = 3'd5;
    localparam t_step STEP_WAIT2   = 3'd6;
    localparam t_step STEP_DRAIN   = 3'd7;

    // configuration register indexes
    localparam t_cfg_idx CFG_PUMP_A  = 3'd0;
    localparam t_cfg_idx CFG_PUMP_B  = 3'd1;
    localparam t_cfg_idx CFG_WAIT    = 3'd2;
    localparam t_cfg_idx CFG_VALVE_C = 3'd3;
    localparam t_cfg_idx CFG_MIX     = 3'd4;

    localparam t_dur RST_PUMP_A  = 16'd3000;
    localparam t_dur RST_PUMP_B  = 16'd4000;
    localparam t_dur RST_WAIT    = 16'd2000;
    localparam t_dur RST_VALVE_C = 16'd5000;
    localparam t_dur RST_MIX     = 16'd10000;
    localparam t_dur DUR_MAX     = 16'hFFFF;

    // bit positions in the latched drive levels
    localparam int unsigned LVL_MOTOR   = 0;
    localparam int unsigned LVL_PUMP_A  = 1;
    localparam int unsigned LVL_PUMP_B  = 2;
    localparam int unsigned LVL_VALVE_C = 3;
    localparam int unsigned LVL_DRAIN   = 4;
    localparam int unsigned LVL_LAMP    = 5;

    typedef struct packed {
        logic start_press;
        logic halt_press;
        logic emergency_ok;
        logic pressure_reached;
        logic ms_tick;
    } t_in_item;

    typedef struct packed {
        logic  motor_on;
        logic  pump_a_on;
        logic  pump_b_on;
        logic  valve_c_open;
        logic  drain_open;
        logic  lamp_on;
        t_step step_number;
        logic  running;
    } t_out_item;

endpackage

`default_nettype wire

### sv/batch_mixer_sequencer_top.sv
// batch_mixer_sequencer_top: run latch, step sequencer, ms counter and drive levels
// depends on bmix_pkg for payload structs, step codes and register indexes
//
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_data) carries one sample of the
//   button, emergency, pressure and tick levels per beat. output channel
//   (o_out_valid / i_out_stall / o_out_data) returns one beat per input beat with
//   the six latched drive levels, the step after this sample and the run latch.
//   a sample's result is registered and shows in the cycle after it is accepted.
//   throughput is one beat per cycle unless stalled; the whole update is one
//   combinational pass from the state registers into state and result registers.
//   a finished result waits in the output register while the receiver stalls; a
//   new sample is taken whenever that register is empty or being taken in the
//   same cycle, so o_in_stall is high only while a result is held by i_out_stall.
//   reset (i_rst_n low, synchronous) clears the run latch, step, counter and drive
//   levels, loads the default durations and empties the output register.
//   duration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data;
//   an unknown index is ignored.
`default_nettype none

module batch_mixer_sequencer_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  bmix_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output bmix_pkg::t_out_item         o_out_data,
    input  wire                         i_cfg_we,
    input  bmix_pkg::t_cfg_idx          i_cfg_idx,
    input  bmix_pkg::t_dur              i_cfg_data
);
    import bmix_pkg::*;

    t_dur              r_pump_a_ms, r_pump_b_ms, r_wait_ms, r_valve_c_ms, r_mix_ms;
    logic              r_run;
    t_step             r_step;
    t_dur              r_cnt;
    logic [LVL_W-1:0]  r_levels;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              n_run;
    t_step             n_step;
    t_dur              n_cnt;
    logic [LVL_W-1:0]  n_levels;

    logic              in_accept;
    t_dur              cnt_tick;
    t_dur              dur;
    logic              hit;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // count is taken before the step logic may clear it
    assign cnt_tick = (i_in_data.ms_tick && r_cnt != DUR_MAX) ? r_cnt + 16'd1 : r_cnt;

    always_comb begin
        case (r_step)
            STEP_PUMP_A:  dur = r_pump_a_ms;
            STEP_PUMP_B:  dur = r_pump_b_ms;
            STEP_VALVE_C: dur = r_valve_c_ms;
            STEP_MIX:     dur = r_mix_ms;
            default:      dur = r_wait_ms;
        endcase
    end

    assign hit = cnt_tick >= dur;

    always_comb begin
        n_levels = r_levels;
        n_step   = r_step;
        n_cnt    = cnt_tick;
        if (i_in_data.start_press && !i_in_data.halt_press) begin
            n_run = 1'b1;
        end else if (i_in_data.halt_press) begin
            n_run = 1'b0;
        end else begin
            n_run = r_run;
        end

        if (n_run) begin
            if (i_in_data.emergency_ok) begin
                case (r_step)
                    STEP_STANDBY: begin
                        n_cnt  = '0;
                        n_step = STEP_PUMP_A;
                    end
                    STEP_PUMP_A:  n_levels[LVL_PUMP_A]  = !hit;
                    STEP_PUMP_B:  n_levels[LVL_PUMP_B]  = !hit;
                    STEP_VALVE_C: n_levels[LVL_VALVE_C] = !hit;
                    STEP_MIX:     n_levels[LVL_MOTOR]   = !hit;
                    STEP_DRAIN: begin
                        n_levels[LVL_DRAIN] = !i_in_data.pressure_reached;
                        if (i_in_data.pressure_reached) begin
                            n_step = STEP_STANDBY;
                        end
                    end
                    default: ;
                endcase
                // timed and waiting steps advance on timeout
                if (r_step != STEP_STANDBY && r_step != STEP_DRAIN && hit) begin
                    n_step = r_step + 3'd1;
                    n_cnt  = '0;
                end
            end else begin
                n_levels = '0;
                n_step   = STEP_STANDBY;
                n_run    = 1'b0;
            end
        end else if (i_in_data.emergency_ok) begin
            n_levels[LVL_LAMP] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump_a_ms  <= RST_PUMP_A;
            r_pump_b_ms  <= RST_PUMP_B;
            r_wait_ms    <= RST_WAIT;
            r_valve_c_ms <= RST_VALVE_C;
            r_mix_ms     <= RST_MIX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PUMP_A:  r_pump_a_ms  <= i_cfg_data;
                CFG_PUMP_B:  r_pump_b_ms  <= i_cfg_data;
                CFG_WAIT:    r_wait_ms    <= i_cfg_data;
                CFG_VALVE_C: r_valve_c_ms <= i_cfg_data;
                CFG_MIX:     r_mix_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_step      <= STEP_STANDBY;
            r_cnt       <= '0;
            r_levels    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_run       <= n_run;
                r_step      <= n_step;
                r_cnt       <= n_cnt;
                r_levels    <= n_levels;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data.motor_on     <= n_levels[LVL_MOTOR];
            r_out_data.pump_a_on    <= n_levels[LVL_PUMP_A];
            r_out_data.pump_b_on    <= n_levels[LVL_PUMP_B];
            r_out_data.valve_c_open <= n_levels[LVL_VALVE_C];
            r_out_data.drain_open   <= n_levels[LVL_DRAIN];
            r_out_data.lamp_on      <= n_levels[LVL_LAMP];
            r_out_data.step_number  <= n_step;
            r_out_data.running      <= n_run;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### sv/bmix_checker.sv
// bmix_checker: port-level assertions for batch_mixer_sequencer_top, bound to the top
// depends on bmix_pkg for payload struct types
`default_nettype none

module bmix_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  o_in_stall,
    input  bmix_pkg::t_in_item   i_in_data,
    input  wire                  o_out_valid,
    input  wire                  i_out_stall,
    input  bmix_pkg::t_out_item  o_out_data
);
    import bmix_pkg::*;

    // every accepted beat gives a result beat on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("no result after accepted beat");

    // input side only backs up while a result is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without held result");

    // stop always leaves the run latch clear
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.halt_press) |=> !o_out_data.running)
        else $error("running after stop");

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("held result changed");

endmodule

bind batch_mixer_sequencer_top bmix_checker u_bmix_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for batch_mixer_sequencer_top
// depends on bmix_pkg and the block's RTL; a scoreboard class predicts every output beat

import bmix_pkg::*;

class mixer_scoreboard;
    t_dur        duration [0:4];
    logic        latched_run;
    t_step       cur_step;
    t_dur        ms_count;
    logic [5:0]  drive_lvl;
    t_out_item   levels_due [$];
    int unsigned mismatches;
    int unsigned compared;

    function new();
        duration[CFG_PUMP_A]  = RST_PUMP_A;
        duration[CFG_PUMP_B]  = RST_PUMP_B;
        duration[CFG_WAIT]    = RST_WAIT;
        duration[CFG_VALVE_C] = RST_VALVE_C;
        duration[CFG_MIX]     = RST_MIX;
        latched_run = 1'b0;
        cur_step    = STEP_STANDBY;
        ms_count    = '0;
        drive_lvl   = '0;
        mismatches  = 0;
        compared    = 0;
    endfunction

    function void write_duration(t_cfg_idx idx, t_dur val);
        if (idx <= CFG_MIX) duration[idx] = val;
    endfunction

    // drive on, and once the time is up drive off and move on
    function void hold_timed(int unsigned bit_pos, t_dur limit);
        drive_lvl[bit_pos] = 1'b1;
        if (ms_count >= limit) begin
            drive_lvl[bit_pos] = 1'b0;
            cur_step = cur_step + 1'b1;
            ms_count = '0;
        end
    endfunction

    function void predict_levels(t_in_item s);
        t_out_item r;
        if (s.ms_tick && ms_count != DUR_MAX) ms_count++;
        if (s.start_press && !s.halt_press) latched_run = 1'b1;
        else if (s.halt_press) latched_run = 1'b0;

        if (latched_run) begin
            if (s.emergency_ok) begin
                case (cur_step)
                    STEP_STANDBY: begin
                        ms_count = '0;
                        cur_step = STEP_PUMP_A;
                    end
                    STEP_PUMP_A:  hold_timed(LVL_PUMP_A, duration[CFG_PUMP_A]);
                    STEP_PUMP_B:  hold_timed(LVL_PUMP_B, duration[CFG_PUMP_B]);
                    STEP_WAIT1, STEP_WAIT2: begin
                        if (ms_count >= duration[CFG_WAIT]) begin
                            cur_step = cur_step + 1'b1;
                            ms_count = '0;
                        end
                    end
                    STEP_VALVE_C: hold_timed(LVL_VALVE_C, duration[CFG_VALVE_C]);
                    STEP_MIX:     hold_timed(LVL_MOTOR, duration[CFG_MIX]);
                    default: begin
                        drive_lvl[LVL_DRAIN] = 1'b1;
                        if (s.pressure_reached) begin
                            drive_lvl[LVL_DRAIN] = 1'b0;
                            cur_step = STEP_STANDBY;
                        end
                    end
                endcase
            end else begin
                // chain broken while running: everything off, lamp too
                drive_lvl   = '0;
                cur_step    = STEP_STANDBY;
                latched_run = 1'b0;
            end
        end else if (s.emergency_ok) begin
            drive_lvl[LVL_LAMP] = 1'b1;
        end

        r.motor_on     = drive_lvl[LVL_MOTOR];
        r.pump_a_on    = drive_lvl[LVL_PUMP_A];
        r.pump_b_on    = drive_lvl[LVL_PUMP_B];
        r.valve_c_open = drive_lvl[LVL_VALVE_C];
        r.drain_open   = drive_lvl[LVL_DRAIN];
        r.lamp_on      = drive_lvl[LVL_LAMP];
        r.step_number  = cur_step;
        r.running      = latched_run;
        levels_due.push_back(r);
    endfunction

    function bit agree(string what, logic [3:0] want, logic [3:0] got);
        if (want === got) return 1'b1;
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        return 1'b0;
    endfunction

    function void check_levels(t_out_item got);
        t_out_item want;
        bit        ok;
        compared++;
        if (levels_due.size() == 0) begin
            $display("%0t: output beat expected none, got %h", $time, got);
            mismatches++;
            return;
        end
        want = levels_due.pop_front();
        ok = agree("motor_on", want.motor_on, got.motor_on);
        ok &= agree("pump_a_on", want.pump_a_on, got.pump_a_on);
        ok &= agree("pump_b_on", want.pump_b_on, got.pump_b_on);
        ok &= agree("valve_c_open", want.valve_c_open, got.valve_c_open);
        ok &= agree("drain_open", want.drain_open, got.drain_open);
        ok &= agree("lamp_on", want.lamp_on, got.lamp_on);
        ok &= agree("step_number", want.step_number, got.step_number);
        ok &= agree("running", want.running, got.running);
        if (!ok) mismatches++;
    endfunction
endclass

module testbench;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned STOPPED_RUN   = 250;
    localparam t_dur        LONG_PUMP_A   = 16'd200;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 200;
    localparam t_cfg_idx    CFG_SPARE_LO  = 3'd5;
    localparam t_cfg_idx    CFG_SPARE_HI  = 3'd7;

    logic      clk;
    logic      rst_n        = 1'b0;
    logic      sample_valid = 1'b0;
    logic      sample_stall;
    t_in_item  sample_data  = '0;
    logic      level_valid;
    logic      level_stall  = 1'b0;
    t_out_item level_data;
    logic      cfg_we       = 1'b0;
    t_cfg_idx  cfg_idx      = '0;
    t_dur      cfg_data     = '0;

    int unsigned     gap_pct = 8;
    int unsigned     cycles  = 0;
    int unsigned     sent    = 0;
    int unsigned     settings_used = 0;
    t_dur            next_dur [0:4];
    mixer_scoreboard sb;

    batch_mixer_sequencer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (sample_valid),
        .o_in_stall  (sample_stall),
        .i_in_data   (sample_data),
        .o_out_valid (level_valid),
        .i_out_stall (level_stall),
        .o_out_data  (level_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d beats still due", cycles, sb.levels_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // output side: random stall, compare every taken beat
    always @(posedge clk) begin
        if (rst_n && level_valid && !level_stall) sb.check_levels(level_data);
        level_stall <= ($urandom_range(0, 99) < gap_pct);
    end

    function automatic t_in_item sample(bit on, bit stop, bit ok, bit press, bit tick);
        t_in_item s;
        s.start_press      = on;
        s.halt_press       = stop;
        s.emergency_ok     = ok;
        s.pressure_reached = press;
        s.ms_tick          = tick;
        return s;
    endfunction

    // mostly a running batch; a few stops, restarts, chain drops and pure noise
    function automatic t_in_item random_sample();
        t_in_item s;
        if ($urandom_range(0, 99) < 4) begin
            s = t_in_item'($urandom);
        end else begin
            s.start_press      = ($urandom_range(0, 99) < 20);
            s.halt_press       = ($urandom_range(0, 99) < 3);
            s.emergency_ok     = ($urandom_range(0, 99) >= 1);
            s.pressure_reached = ($urandom_range(0, 99) < 30);
            s.ms_tick          = ($urandom_range(0, 99) < 80);
        end
        return s;
    endfunction

    function automatic t_dur pick_duration(int unsigned phase);
        if (phase == 0) return '0;
        if (phase == 1) return DUR_MAX;
        if ($urandom_range(0, 19) == 0) return t_dur'($urandom_range(13, DUR_MAX));
        if ($urandom_range(0, 3) == 0) return t_dur'($urandom_range(0, 12));
        return t_dur'($urandom_range(1, 4));
    endfunction

    task automatic send_sample(input t_in_item s);
        while ($urandom_range(0, 99) < gap_pct) begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= s;
        do @(posedge clk); while (sample_stall);
        sb.predict_levels(s);
        sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_dur val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_duration(idx, val);
    endtask

    // block is idle here; junk to an unused index must not land anywhere
    task automatic set_durations(input t_cfg_idx spare, input t_dur junk);
        for (int i = CFG_PUMP_A; i <= CFG_MIX; i++) write_reg(t_cfg_idx'(i), next_dur[i]);
        write_reg(spare, junk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic drain_phase();
        sample_valid <= 1'b0;
        while (sb.levels_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_directed();
        // reset durations: lamp, button priority, stop and resume, chain drop
        send_sample(sample(0, 0, 0, 0, 0));
        send_sample(sample(0, 0, 1, 0, 1));
        send_sample(sample(1, 1, 1, 0, 0));
        send_sample(sample(1, 0, 1, 0, 1));
        send_sample(sample(0, 0, 1, 1, 1));
        send_sample(sample(0, 1, 1, 0, 1));
        send_sample(sample(1, 0, 1, 0, 0));
        send_sample(sample(0, 0, 0, 1, 1));
        send_sample(sample(0, 1, 0, 0, 0));
        drain_phase();

        // zero durations: each timed step ends on its first beat
        for (int i = CFG_PUMP_A; i <= CFG_MIX; i++) next_dur[i] = '0;
        set_durations(CFG_SPARE_LO, DUR_MAX);
        send_sample(sample(1, 0, 1, 0, 1));
        repeat (7) send_sample(sample(0, 0, 1, 0, 0));
        send_sample(sample(0, 0, 1, 1, 0));
        send_sample(sample(0, 0, 1, 1, 1));
        drain_phase();
    endtask

    // counter keeps counting while stopped, so a long pump step ends right on resume
    task automatic run_stopped_count();
        next_dur[CFG_PUMP_A] = LONG_PUMP_A;
        for (int i = CFG_PUMP_B; i <= CFG_MIX; i++) next_dur[i] = 16'd1;
        set_durations(CFG_SPARE_LO + 1'b1, 16'h5A5A);
        send_sample(sample(1, 0, 1, 0, 0));
        repeat (STOPPED_RUN) send_sample(sample(0, 1, 1, 0, 1));
        send_sample(sample(1, 0, 1, 0, 0));
        send_sample(sample(0, 0, 1, 0, 1));
        drain_phase();
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_stopped_count();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int i = CFG_PUMP_A; i <= CFG_MIX; i++) next_dur[i] = pick_duration(p);
            set_durations(t_cfg_idx'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          t_dur'($urandom));
            gap_pct = (p == 4) ? 0 : 8;
            repeat (PHASE_ITEMS) send_sample(random_sample());
            drain_phase();
        end
        gap_pct = 8;
        repeat (8) @(posedge clk);

        $display("drove %0d samples over %0d duration settings, compared %0d output beats",
                 sent, settings_used, sb.compared);
        $display("covered zero and full-scale durations, counting while stopped, chain loss");
        if (sb.mismatches == 0 && sb.levels_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### files.f
sv/bmix_pkg.sv
sv/batch_mixer_sequencer_top.sv
sv/bmix_checker.sv
test/testbench.sv
